// ===== src/bpq_pkg.sv =====
// Shared types and constants of the bitmap priority ready queue.
package bpq_pkg;

  localparam int unsigned LEVELS  = 32;
  localparam int unsigned SERVERS = 256;
  localparam int unsigned LVL_W   = $clog2(LEVELS);
  localparam int unsigned SRV_W   = $clog2(SERVERS);
  localparam int unsigned LINK_W  = SRV_W + 1;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_PEEK     = 2'd1,
    REQ_RETRIEVE = 2'd2,
    REQ_RSVD     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_LINK,
    S_INS_CLR,
    S_HEAD,
    S_RET,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] server_id;
    logic [7:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] head_server;
    logic [4:0] head_level;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    cap_head;
    logic    ins_upd;
    logic    ins_clr;
    logic    ret_upd;
    logic    load_out;
    status_e out_status;
    logic    out_head;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       range_err;
    logic       empty;
  } dp_stat_t;

endpackage

// ===== src/bpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bpq_dpath.sv =====
// Datapath: request registers, level bitmap, head/tail/link tables and result register.
module bpq_dpath import bpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     in_item_i,
  input  ctl_cmd_t cmd_i,
  output dp_stat_t stat_o,
  output rsp_t     out_item_o
);

  logic [1:0]        req_q;
  logic [SRV_W-1:0]  srv_q;
  logic [LVL_W-1:0]  pri_q;
  logic [LVL_W-1:0]  lev_q;
  logic              range_q;
  logic              empty_q;
  logic [LEVELS-1:0] bitmap_q, bitmap_d;
  logic [SRV_W-1:0]  h_q;
  rsp_t              out_q;

  logic [LVL_W-1:0]  low_lev;
  logic              bit_set;

  logic [SRV_W-1:0]  head_rdata, tail_rdata;
  logic [LINK_W-1:0] link_rdata;
  logic              link_valid;

  logic              head_we;
  logic [LVL_W-1:0]  head_waddr;
  logic [SRV_W-1:0]  head_wdata;
  logic              link_we;
  logic [SRV_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;

  // Lowest set bit of the bitmap
  always_comb begin
    low_lev = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (bitmap_q[i]) begin
        low_lev = LVL_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= in_item_i.req_type;
      srv_q   <= in_item_i.server_id[SRV_W-1:0];
      pri_q   <= in_item_i.priority_req[LVL_W-1:0];
      range_q <= (32'(in_item_i.priority_req) >= LEVELS);
      lev_q   <= low_lev;
      empty_q <= ~(|bitmap_q);
    end
    if (cmd_i.cap_head) begin
      h_q <= head_rdata;
    end
    if (cmd_i.load_out) begin
      out_q.status      <= cmd_i.out_status;
      out_q.head_server <= cmd_i.out_head ? 8'(h_q) : '0;
      out_q.head_level  <= cmd_i.out_head ? 5'(lev_q) : '0;
    end
  end

  assign bit_set    = bitmap_q[pri_q];
  assign link_valid = link_rdata[LINK_W-1];

  always_comb begin
    bitmap_d = bitmap_q;
    if (cmd_i.ins_upd) begin
      bitmap_d[pri_q] = 1'b1;
    end
    if (cmd_i.ret_upd && !link_valid) begin
      bitmap_d[lev_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q <= '0;
    end else begin
      bitmap_q <= bitmap_d;
    end
  end

  // Head table: new head on insert into an empty level, successor on retrieve
  always_comb begin
    head_we    = 1'b0;
    head_waddr = pri_q;
    head_wdata = srv_q;
    if (cmd_i.ins_upd && !bit_set) begin
      head_we = 1'b1;
    end else if (cmd_i.ret_upd && link_valid) begin
      head_we    = 1'b1;
      head_waddr = lev_q;
      head_wdata = link_rdata[SRV_W-1:0];
    end
  end

  // Link table: chain old tail, clear new server's link, drop removed head's link
  always_comb begin
    link_we    = 1'b0;
    link_waddr = srv_q;
    link_wdata = '0;
    if (cmd_i.ins_upd && bit_set) begin
      link_we    = 1'b1;
      link_waddr = tail_rdata;
      link_wdata = {1'b1, srv_q};
    end else if (cmd_i.ins_clr) begin
      link_we = 1'b1;
    end else if (cmd_i.ret_upd) begin
      link_we    = 1'b1;
      link_waddr = h_q;
    end
  end

  bpq_ram #(.Width(SRV_W), .Depth(LEVELS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (lev_q),
    .rdata_o (head_rdata)
  );

  bpq_ram #(.Width(SRV_W), .Depth(LEVELS)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_upd),
    .waddr_i (pri_q),
    .wdata_i (srv_q),
    .raddr_i (pri_q),
    .rdata_o (tail_rdata)
  );

  bpq_ram #(.Width(LINK_W), .Depth(SERVERS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (head_rdata),
    .rdata_o (link_rdata)
  );

  assign stat_o.req       = req_q;
  assign stat_o.range_err = range_q;
  assign stat_o.empty     = empty_q;
  assign out_item_o       = out_q;

endmodule

// ===== src/bpq_ctrl.sv =====
// Controller: request sequencing state machine and output handshake.
module bpq_ctrl import bpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    hd_q, hd_d;
  logic    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= ST_OK;
      hd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      hd_q        <= hd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    hd_d        = hd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o            = '0;
    cmd_o.out_status = st_q;
    cmd_o.out_head   = hd_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d = ST_OK;
        hd_d = 1'b0;
        unique case (stat_i.req)
          REQ_INSERT: begin
            if (stat_i.range_err) begin
              st_d    = ST_RANGE;
              state_d = S_RESP;
            end else begin
              state_d = S_INS_LINK;
            end
          end
          REQ_PEEK, REQ_RETRIEVE: begin
            if (stat_i.empty) begin
              st_d    = ST_EMPTY;
              state_d = S_RESP;
            end else begin
              hd_d    = 1'b1;
              state_d = S_HEAD;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_INS_LINK: begin
        cmd_o.ins_upd = 1'b1;
        state_d       = S_INS_CLR;
      end
      S_INS_CLR: begin
        cmd_o.ins_clr = 1'b1;
        state_d       = S_RESP;
      end
      S_HEAD: begin
        cmd_o.cap_head = 1'b1;
        state_d        = (stat_i.req == REQ_RETRIEVE) ? S_RET : S_RESP;
      end
      S_RET: begin
        cmd_o.ret_upd = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        // Hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/bitmap_priority_ready_queue.sv =====
// A new item is taken only once the last has reached the output register, as it visits
// the registered-read head, tail and link RAMs in turn; a finished result waits in that
// output register while the next item is taken. Reset clears the level bitmap (all levels
// empty) and the control state; the table RAMs are not cleared and need no clearing pass.
module bitmap_priority_ready_queue import bpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_item_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bpq_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule
